/* hdl/quadratic_cost_arc_splitter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the arc splitter
// Shared concurrent assertion forms; clock clk, synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_COST_ARC_SPLITTER_ASSERT_SVH
`define QUADRATIC_COST_ARC_SPLITTER_ASSERT_SVH

// Same-cycle implication
`define QCAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qcas: implication check failed");

// Next-cycle implication
`define QCAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qcas: next-cycle check failed");

`endif

/* hdl/qcas_pkg.sv */
// ----------------------------------------------------------------------------
// qcas_pkg
// Types, widths and codes shared by the arc splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qcas_pkg;

  localparam int MAX_SEGMENTS_DEF = 62;

  localparam int CAP_W      = 32;
  localparam int PRICE_W    = 63;
  localparam int EXON_W     = 16;
  localparam int BDIV_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  // shared unit: dividend/quotient width, accumulator width, iteration count
  localparam int DQ_W  = 65;
  localparam int ACC_W = 80;
  localparam int CNT_W = 7;
  localparam int SUM_W = 33;

  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE      = 2'd0,
    CFG_OVERFLOW_PRICE = 2'd1,
    CFG_COST_SCALE     = 2'd2,
    CFG_BIAS_DIVISOR   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [CNT_W-1:0] count;
    logic [ACC_W-1:0] a;
    logic [CAP_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] result;
  } alu_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_NSTEP,
    S_OUT,
    S_MUL1,
    S_DIV,
    S_MUL2
  } seq_state_t;

endpackage

`default_nettype wire

/* hdl/qcas_in_if.sv */
// ----------------------------------------------------------------------------
// qcas_in_if
// Input channel: one edge to split per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcas_in_if import qcas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CAP_W-1:0]  total_capacity;
  logic [CAP_W-1:0]  original_capacity;
  logic [EXON_W-1:0] exon_total;

  modport source (output valid, output total_capacity, output original_capacity,
                  output exon_total, input ready);
  modport sink   (input valid, input total_capacity, input original_capacity,
                  input exon_total, output ready);
endinterface

`default_nettype wire

/* hdl/qcas_out_if.sv */
// ----------------------------------------------------------------------------
// qcas_out_if
// Result channel: one linear segment per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qcas_out_if import qcas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CAP_W-1:0]   arc_capacity;
  logic [PRICE_W-1:0] arc_price;
  logic               last_arc;
  logic               clipped;

  modport source (output valid, output arc_capacity, output arc_price,
                  output last_arc, output clipped, input ready);
  modport sink   (input valid, input arc_capacity, input arc_price,
                  input last_arc, input clipped, output ready);
endinterface

`default_nettype wire

/* hdl/qcas_alu.sv */
// ----------------------------------------------------------------------------
// qcas_alu
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qcas_alu import qcas_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  alu_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] opa_r, opa_nxt;
  logic [CAP_W-1:0] opb_r, opb_nxt;
  logic [CAP_W-1:0] rem_r, rem_nxt;

  logic [CAP_W:0]   trial;
  logic             fits;

  // divide: dividend MSB enters the remainder, quotient bit enters the LSB
  assign trial = {rem_r, acc_r[DQ_W-1]};
  assign fits  = (trial >= {1'b0, opb_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    opa_nxt  = opa_r;
    opb_nxt  = opb_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = req.count;
      opa_nxt  = req.a;
      opb_nxt  = req.b;
      rem_nxt  = '0;
      acc_nxt  = (req.op == ALU_DIV) ? req.a : '0;
    end else if (busy_r) begin
      case (op_r)
        ALU_MUL: begin
          if (opb_r[0]) acc_nxt = acc_r + opa_r;
          opa_nxt = {opa_r[ACC_W-2:0], 1'b0};
          opb_nxt = {1'b0, opb_r[CAP_W-1:1]};
        end
        ALU_DIV: begin
          rem_nxt = fits ? CAP_W'(trial - {1'b0, opb_r}) : trial[CAP_W-1:0];
          acc_nxt = {acc_r[ACC_W-2:0], fits};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= ALU_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

`include "quadratic_cost_arc_splitter_assert.svh"

  `QCAS_ASSERT_IMP(a_alu_no_restart, req.start, !busy_r)
  `QCAS_ASSERT_NXT(a_alu_finish, busy_r && !req.start && cnt_r == CNT_W'(1), done_r && !busy_r)
  `QCAS_ASSERT_IMP(a_alu_rem_bound, busy_r && op_r == ALU_DIV, rem_r < opb_r)

endmodule

`default_nettype wire

/* hdl/qcas_seq.sv */
// ----------------------------------------------------------------------------
// qcas_seq
// Sequencer: walks the segments of one edge, drives the shared unit and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qcas_seq import qcas_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  qcas_in_if.sink                 in_ch,
  qcas_out_if.source              out_ch,
  input  wire logic [CAP_W-1:0]   step_size,
  input  wire logic [PRICE_W-1:0] overflow_price,
  input  wire logic [CAP_W-1:0]   cost_scale,
  input  wire logic [BDIV_W-1:0]  bias_divisor,
  output alu_req_t                alu_req,
  input  wire alu_rsp_t           alu_rsp
);

  localparam int KK_W = $clog2(MAX_SEGMENTS + 1);

  seq_state_t state_r, state_nxt;

  logic [CAP_W-1:0]   total_r, total_nxt;
  logic [CAP_W-1:0]   orig_r, orig_nxt;
  logic [EXON_W-1:0]  mult_r, mult_nxt;
  logic [CAP_W-1:0]   mark_r, mark_nxt;
  logic [KK_W-1:0]    nsteps_r, nsteps_nxt;
  logic [KK_W-1:0]    kk_r, kk_nxt;
  logic [CAP_W-1:0]   c_r, c_nxt;
  logic               clip_r, clip_nxt;
  logic [CAP_W-1:0]   pcap_r, pcap_nxt;
  logic [PRICE_W-1:0] pprice_r, pprice_nxt;
  logic               plast_r, plast_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0]   out_cap_r, out_cap_nxt;
  logic [PRICE_W-1:0] out_price_r, out_price_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_clip_r, out_clip_nxt;

  logic               accept;
  logic               load;
  logic [CAP_W-1:0]   step_eff;
  logic [BDIV_W-1:0]  bdiv_eff;
  logic [CAP_W-1:0]   q32;
  logic [DQ_W-1:0]    q65;
  logic [CAP_W:0]     c_step;
  logic [SUM_W-1:0]   sum_step;
  logic [SUM_W-1:0]   sum_left;
  logic [KK_W-1:0]    kk_inc;
  logic               step_clip;

  assign step_eff  = (step_size == '0) ? CAP_W'(1) : step_size;
  assign bdiv_eff  = (bias_divisor == '0) ? BDIV_W'(1) : bias_divisor;
  assign accept    = in_ch.valid && in_ch.ready;
  assign load      = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign q32       = alu_rsp.result[CAP_W-1:0];
  assign q65       = alu_rsp.result[DQ_W-1:0];
  assign c_step    = {1'b0, c_r} + {1'b0, step_eff};
  assign sum_step  = SUM_W'({1'b0, c_r} + c_step);
  assign sum_left  = {1'b0, mark_r} + {1'b0, c_r};
  assign kk_inc    = kk_r + KK_W'(1);
  assign step_clip = (q32 > CAP_W'(MAX_SEGMENTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_ch.original_capacity != '0) state_nxt = S_MARK;
      end
      S_MARK:  if (alu_rsp.done) state_nxt = S_NSTEP;
      S_NSTEP: if (alu_rsp.done) state_nxt = S_OUT;
      S_OUT: begin
        if (load) state_nxt = plast_r ? S_IDLE : S_MUL1;
      end
      S_MUL1: if (alu_rsp.done) state_nxt = S_DIV;
      S_DIV: begin
        if (alu_rsp.done) begin
          if (mult_r == '0 || q65[DQ_W-1:PRICE_W] != '0) state_nxt = S_OUT;
          else state_nxt = S_MUL2;
        end
      end
      S_MUL2:  if (alu_rsp.done) state_nxt = S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    total_nxt     = total_r;
    orig_nxt      = orig_r;
    mult_nxt      = mult_r;
    mark_nxt      = mark_r;
    nsteps_nxt    = nsteps_r;
    kk_nxt        = kk_r;
    c_nxt         = c_r;
    clip_nxt      = clip_r;
    pcap_nxt      = pcap_r;
    pprice_nxt    = pprice_r;
    plast_nxt     = plast_r;
    out_cap_nxt   = out_cap_r;
    out_price_nxt = out_price_r;
    out_last_nxt  = out_last_r;
    out_clip_nxt  = out_clip_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    alu_req       = '0;
    alu_req.op    = ALU_MUL;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          total_nxt     = in_ch.total_capacity;
          orig_nxt      = in_ch.original_capacity;
          mult_nxt      = (in_ch.exon_total == '0) ? '0 : in_ch.exon_total - EXON_W'(1);
          alu_req.start = (in_ch.original_capacity != '0);
          alu_req.op    = ALU_DIV;
          alu_req.count = CNT_W'(CAP_W);
          alu_req.a     = ACC_W'({in_ch.original_capacity, (DQ_W - CAP_W)'(0)});
          alu_req.b     = CAP_W'(bdiv_eff);
        end
      end
      S_MARK: begin
        if (alu_rsp.done) begin
          mark_nxt      = q32;
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.count = CNT_W'(CAP_W);
          alu_req.a     = ACC_W'({q32, (DQ_W - CAP_W)'(0)});
          alu_req.b     = step_eff;
        end
      end
      S_NSTEP: begin
        if (alu_rsp.done) begin
          clip_nxt   = step_clip;
          nsteps_nxt = step_clip ? KK_W'(MAX_SEGMENTS) : q32[KK_W-1:0];
          kk_nxt     = '0;
          c_nxt      = '0;
          pcap_nxt   = (total_r > mark_r) ? total_r - mark_r : '0;
          pprice_nxt = overflow_price;
          // no steps and an empty share: the overflow segment is the only one
          plast_nxt  = (q32 == '0) && (mark_r == '0);
        end
      end
      S_OUT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_cap_nxt   = pcap_r;
          out_price_nxt = pprice_r;
          out_last_nxt  = plast_r;
          out_clip_nxt  = clip_r;
          if (!plast_r) begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MUL;
            alu_req.count = CNT_W'(CAP_W);
            alu_req.b     = cost_scale;
            if (kk_r < nsteps_r) begin
              alu_req.a = ACC_W'(sum_step);
              pcap_nxt  = step_eff;
              plast_nxt = (kk_inc == nsteps_r) && (c_step == {1'b0, mark_r});
              kk_nxt    = kk_inc;
              c_nxt     = c_step[CAP_W-1:0];
            end else begin
              // leftover up to the regular share
              alu_req.a = ACC_W'(sum_left);
              pcap_nxt  = mark_r - c_r;
              plast_nxt = 1'b1;
            end
          end
        end
      end
      S_MUL1: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.op    = ALU_DIV;
          alu_req.count = CNT_W'(DQ_W);
          alu_req.a     = ACC_W'(q65);
          alu_req.b     = orig_r;
        end
      end
      S_DIV: begin
        if (alu_rsp.done) begin
          if (mult_r == '0) begin
            pprice_nxt = '0;
          end else if (q65[DQ_W-1:PRICE_W] != '0) begin
            pprice_nxt = PRICE_MAX;
          end else begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_MUL;
            alu_req.count = CNT_W'(EXON_W);
            alu_req.a     = ACC_W'(q65[PRICE_W-1:0]);
            alu_req.b     = CAP_W'(mult_r);
          end
        end
      end
      S_MUL2: begin
        if (alu_rsp.done) begin
          pprice_nxt = (alu_rsp.result[ACC_W-1:PRICE_W] != '0) ? PRICE_MAX
                                                               : alu_rsp.result[PRICE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nsteps_r    <= '0;
      kk_r        <= '0;
      plast_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nsteps_r    <= nsteps_nxt;
      kk_r        <= kk_nxt;
      plast_r     <= plast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r     <= total_nxt;
    orig_r      <= orig_nxt;
    mult_r      <= mult_nxt;
    mark_r      <= mark_nxt;
    c_r         <= c_nxt;
    clip_r      <= clip_nxt;
    pcap_r      <= pcap_nxt;
    pprice_r    <= pprice_nxt;
    out_cap_r   <= out_cap_nxt;
    out_price_r <= out_price_nxt;
    out_last_r  <= out_last_nxt;
    out_clip_r  <= out_clip_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.arc_capacity = out_cap_r;
  assign out_ch.arc_price    = out_price_r;
  assign out_ch.last_arc     = out_last_r;
  assign out_ch.clipped      = out_clip_r;

`include "quadratic_cost_arc_splitter_assert.svh"

  `QCAS_ASSERT_IMP(a_seq_kk_bound, state_r != S_IDLE, kk_r <= nsteps_r)
  `QCAS_ASSERT_IMP(a_seq_idle_unit, in_ch.ready, !alu_rsp.busy && !alu_rsp.done)
  `QCAS_ASSERT_IMP(a_seq_done_waiting, alu_rsp.done, state_r == S_MARK || state_r == S_NSTEP || state_r == S_MUL1 || state_r == S_DIV || state_r == S_MUL2)

endmodule

`default_nettype wire

/* hdl/quadratic_cost_arc_splitter.sv */
// ----------------------------------------------------------------------------
// quadratic_cost_arc_splitter
// Splits the quadratic cost of one edge into priced linear segments.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one edge per transaction (total, original capacity, exons);
//   out_ch returns its segments in order: overflow segment first, then up to
//   MAX_SEGMENTS step segments, then any leftover segment; last_arc marks the
//   final one. An edge with zero original capacity gives no segments.
//   cfg_we/cfg_idx/cfg_wdata write the four settings while the block is idle.
// Timing:
//   One edge at a time; in_ch.ready is high only between edges. All multiplies
//   and divides run one bit per cycle through a single shared unit: the first
//   segment follows two divides (regular share, then step count), and each
//   further segment a multiply, a divide and a final multiply; the final
//   multiply is skipped when the price is zero or saturated. The result
//   register lets the next edge be accepted while the last segment is still
//   waiting; a stalled receiver halts the sequencer once the next segment is
//   ready.
// Reset:
//   rst_n (synchronous) returns to idle, drops out_ch.valid and restores
//   step 1, overflow price 0, scale 1, bias divisor 5.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_cost_arc_splitter import qcas_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  qcas_in_if.sink                    in_ch,
  qcas_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CAP_W-1:0]   step_size_r;
  logic [PRICE_W-1:0] overflow_price_r;
  logic [CAP_W-1:0]   cost_scale_r;
  logic [BDIV_W-1:0]  bias_divisor_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r      <= CAP_W'(1);
      overflow_price_r <= '0;
      cost_scale_r     <= CAP_W'(1);
      bias_divisor_r   <= BDIV_W'(5);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_STEP_SIZE:      step_size_r      <= cfg_wdata[CAP_W-1:0];
        CFG_OVERFLOW_PRICE: overflow_price_r <= cfg_wdata[PRICE_W-1:0];
        CFG_COST_SCALE:     cost_scale_r     <= cfg_wdata[CAP_W-1:0];
        CFG_BIAS_DIVISOR:   bias_divisor_r   <= cfg_wdata[BDIV_W-1:0];
        default: ;
      endcase
    end
  end

  qcas_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  qcas_seq #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .step_size      (step_size_r),
    .overflow_price (overflow_price_r),
    .cost_scale     (cost_scale_r),
    .bias_divisor   (bias_divisor_r),
    .alu_req        (alu_req),
    .alu_rsp        (alu_rsp)
  );

endmodule

`default_nettype wire
